[hw/rtl/dda_pkg.sv]
// Shared types, constants and FSM encoding for the DDA line rasterizer.
// No dependencies; every other file in hw/rtl except dda_stream_if refers to this package.
`default_nettype none

package dda_pkg;

    localparam int COORD_W       = 6;
    localparam int TILE_SIZE_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_line;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_pixel;
    } t_pixel;

    // request to the serial divider
    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dividend;
        logic [COORD_W-1:0] divisor;
    } t_div_req;

    // control from the sequencer to the pixel stepper
    typedef struct packed {
        logic load;
        logic run;
    } t_step_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/dda_stream_if.sv]
// Valid/ready stream interface used for the line and pixel channels.
// Payload type is a parameter; the types come from dda_pkg.
`default_nettype none

interface dda_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/dda_div.sv]
// Serial restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit per cycle.
// Depends on dda_pkg (t_div_req, COORD_W).
`default_nettype none

module dda_div #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dda_pkg::t_div_req    i_req,
    output logic                      o_done,
    output logic [FRAC_BITS-1:0]      o_quot
);
    localparam int CW    = dda_pkg::COORD_W;
    localparam int CNT_W = $clog2(FRAC_BITS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_div;
    logic [FRAC_BITS-1:0] r_quot;

    logic [CW:0] w_shift;
    logic [CW:0] w_diff;
    logic        w_ge;

    // partial remainder is CW bits wide, so the shifted value fits CW+1 bits
    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= CNT_W'(FRAC_BITS - 1);
            r_rem <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_rem  <= w_ge ? w_diff[CW-1:0] : w_shift[CW-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[hw/rtl/dda_step.sv]
// Pixel stepper: two fixed-point accumulators, rounding, and the output register.
// Depends on dda_pkg and dda_stream_if.
`default_nettype none

module dda_step #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire dda_pkg::t_step_ctl                    i_ctl,
    input  wire logic [dda_pkg::COORD_W-1:0]           i_x0,
    input  wire logic [dda_pkg::COORD_W-1:0]           i_y0,
    input  wire logic [dda_pkg::COORD_W-1:0]           i_steps,
    input  wire logic [dda_pkg::COORD_W+FRAC_BITS-1:0] i_inc_x,
    input  wire logic [dda_pkg::COORD_W+FRAC_BITS-1:0] i_inc_y,
    output logic                                       o_done,
    dda_stream_if.source                               o_pix
);
    localparam int CW    = dda_pkg::COORD_W;
    localparam int ACC_W = CW + FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic [ACC_W-1:0] r_acc_x, r_acc_y;
    logic [ACC_W-1:0] r_inc_x, r_inc_y;
    logic [CW-1:0]    r_cnt, r_steps;
    logic             r_out_valid;
    dda_pkg::t_pixel  r_pix;

    logic             w_fire;
    logic             w_last;
    logic [ACC_W-1:0] w_rnd_x, w_rnd_y;

    // accumulators never go negative and stay below TILE_SIZE, so no clamp is needed
    assign w_rnd_x = r_acc_x + HALF;
    assign w_rnd_y = r_acc_y + HALF;
    assign w_last  = r_cnt == r_steps;
    assign w_fire  = i_ctl.run && (!r_out_valid || o_pix.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc_x <= {i_x0, FRAC_BITS'(0)};
            r_acc_y <= {i_y0, FRAC_BITS'(0)};
            r_inc_x <= i_inc_x;
            r_inc_y <= i_inc_y;
            r_steps <= i_steps;
            r_cnt   <= '0;
        end else if (w_fire) begin
            r_pix.pixel_x    <= w_rnd_x[ACC_W-1:FRAC_BITS];
            r_pix.pixel_y    <= w_rnd_y[ACC_W-1:FRAC_BITS];
            r_pix.last_pixel <= w_last;
            r_acc_x          <= r_acc_x + r_inc_x;
            r_acc_y          <= r_acc_y + r_inc_y;
            r_cnt            <= r_cnt + CW'(1);
        end
    end

    assign o_done        = w_fire && w_last;
    assign o_pix.valid   = r_out_valid;
    assign o_pix.payload = r_pix;

endmodule

`default_nettype wire

[hw/rtl/dda_line_rasterizer_top.sv]
// DDA line rasterizer top level: input prep, sequencer FSM, divider and stepper.
// Depends on dda_pkg, dda_stream_if, dda_div and dda_step.
//
// Usage:
//  - i_line (sink) takes one line segment per transfer: start_x/start_y/end_x/end_y.
//    Coordinates above TILE_SIZE-1 are saturated. Endpoints are ordered left to
//    right, vertical lines bottom to top.
//  - o_pix (source) gives steps+1 pixels per line, steps = max(|dx|,|dy|),
//    last_pixel set on the final one. Equal endpoints give a single pixel.
//  - Timing: after the line transfer the serial divider computes the minor-axis
//    increment (one quotient bit per cycle), then one pixel leaves per cycle
//    while the receiver is ready. The divider is always run, even for
//    axis-aligned, diagonal and single-point lines.
//  - i_line.ready is high only while the sequencer is idle; one line is in flight.
//  - Output is registered: a stalled receiver holds the current pixel and
//    halts the stepper; the next line may be taken while the last pixel waits.
//  - Reset (synchronous, active low) drops any line in flight and clears
//    the output valid.
`default_nettype none

module dda_line_rasterizer_top #(
    parameter int TILE_SIZE = dda_pkg::TILE_SIZE_DEF,
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    dda_stream_if.sink    i_line,
    dda_stream_if.source  o_pix
);
    localparam int CW    = dda_pkg::COORD_W;
    localparam int ACC_W = CW + FRAC_BITS;
    localparam logic [CW-1:0]    MAX_COORD = CW'(TILE_SIZE - 1);
    localparam logic [ACC_W-1:0] ONE       = ACC_W'(1) << FRAC_BITS;

    dda_pkg::t_state r_state, n_state;

    // line setup, captured on the input transfer
    logic [CW-1:0] r_x0, r_y0, r_steps;
    logic          r_y_neg, r_x_major, r_y_major;

    logic          w_accept;
    logic [CW-1:0] w_sx, w_sy, w_ex, w_ey;
    logic [CW-1:0] w_x0, w_y0, w_x1, w_y1;
    logic          w_swap;
    logic [CW-1:0] w_adx, w_ady, w_steps, w_minor;
    logic          w_y_neg;

    dda_pkg::t_div_req    w_div_req;
    logic                 w_div_done;
    logic [FRAC_BITS-1:0] w_quot;
    dda_pkg::t_step_ctl   w_step_ctl;
    logic                 w_step_done;
    logic [ACC_W-1:0]     w_inc_x, w_inc_y, w_quot_ext;

    assign w_accept = i_line.valid && i_line.ready;

    // saturate into the tile
    assign w_sx = (i_line.payload.start_x > MAX_COORD) ? MAX_COORD : i_line.payload.start_x;
    assign w_sy = (i_line.payload.start_y > MAX_COORD) ? MAX_COORD : i_line.payload.start_y;
    assign w_ex = (i_line.payload.end_x > MAX_COORD) ? MAX_COORD : i_line.payload.end_x;
    assign w_ey = (i_line.payload.end_y > MAX_COORD) ? MAX_COORD : i_line.payload.end_y;

    // left to right, vertical bottom to top; dx is then never negative
    assign w_swap = (w_sx > w_ex) || ((w_sx == w_ex) && (w_sy > w_ey));
    assign w_x0   = w_swap ? w_ex : w_sx;
    assign w_y0   = w_swap ? w_ey : w_sy;
    assign w_x1   = w_swap ? w_sx : w_ex;
    assign w_y1   = w_swap ? w_sy : w_ey;

    assign w_adx   = w_x1 - w_x0;
    assign w_y_neg = w_y1 < w_y0;
    assign w_ady   = w_y_neg ? (w_y0 - w_y1) : (w_y1 - w_y0);
    assign w_steps = (w_adx > w_ady) ? w_adx : w_ady;
    assign w_minor = (w_adx > w_ady) ? w_ady : w_adx;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x0      <= w_x0;
            r_y0      <= w_y0;
            r_steps   <= w_steps;
            r_y_neg   <= w_y_neg;
            r_x_major <= w_adx == w_steps;
            r_y_major <= w_ady == w_steps;
        end
    end

    // FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dda_pkg::S_IDLE: if (w_accept)    n_state = dda_pkg::S_DIV;
            dda_pkg::S_DIV:  if (w_div_done)  n_state = dda_pkg::S_EMIT;
            dda_pkg::S_EMIT: if (w_step_done) n_state = dda_pkg::S_IDLE;
            default:                          n_state = dda_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_line.ready       = 1'b0;
        w_step_ctl.load    = 1'b0;
        w_step_ctl.run     = 1'b0;
        case (r_state)
            dda_pkg::S_IDLE: i_line.ready    = 1'b1;
            dda_pkg::S_DIV:  w_step_ctl.load = w_div_done;
            dda_pkg::S_EMIT: w_step_ctl.run  = 1'b1;
            default: ;
        endcase
    end

    // minor-axis magnitude over steps; divisor of zero only for a single point,
    // where the quotient is never used
    assign w_div_req.start    = w_accept;
    assign w_div_req.dividend = w_minor;
    assign w_div_req.divisor  = w_steps;

    dda_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // major axis steps by exactly one pixel; minor axis truncated toward zero
    assign w_quot_ext = ACC_W'(w_quot);
    assign w_inc_x    = r_x_major ? ONE : w_quot_ext;
    assign w_inc_y    = r_y_major ? (r_y_neg ? -ONE : ONE)
                                  : (r_y_neg ? -w_quot_ext : w_quot_ext);

    dda_step #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_step_ctl),
        .i_x0    (r_x0),
        .i_y0    (r_y0),
        .i_steps (r_steps),
        .i_inc_x (w_inc_x),
        .i_inc_y (w_inc_y),
        .o_done  (w_step_done),
        .o_pix   (o_pix)
    );

    // assertions
    a_accept_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == dda_pkg::S_DIV)
        else $error("line transfer did not start the divider");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == dda_pkg::S_DIV)
        else $error("divider finished outside the divide phase");

    a_step_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_done |-> r_state == dda_pkg::S_EMIT)
        else $error("last pixel produced outside the emit phase");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step_done |=> (r_state == dda_pkg::S_IDLE) && o_pix.valid && o_pix.payload.last_pixel)
        else $error("last pixel not presented on return to idle");

endmodule

`default_nettype wire
